[rtl/keyboard_buffer_device_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef KEYBOARD_BUFFER_DEVICE_TOP_ASSERT_SVH
`define KEYBOARD_BUFFER_DEVICE_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define KBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("keyboard buffer check failed");

// Checked on every rising edge, reset included.
`define KBD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("keyboard buffer reset check failed");

`endif

[rtl/kbd_pkg.sv]
`default_nettype none

package kbd_pkg;

    // Default sizes
    localparam int FIFO_DEPTH_DEF      = 8;
    localparam int HELD_SLOT_COUNT_DEF = 8;

    // Command codes
    typedef enum logic [2:0] {
        OP_KEY_DOWN = 3'd0,
        OP_KEY_UP   = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_GET      = 3'd3,
        OP_CHECK    = 3'd4,
        OP_SET_IRQ  = 3'd5
    } op_t;

    // Request payload
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] key_code;
        logic [15:0] message_value;
    } req_t;

    // Response payload
    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_data;
        logic        interrupt_request;
        logic [15:0] interrupt_message;
    } rsp_t;

    // Typed-key FIFO controls
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctl_t;

    // Held-key set controls
    typedef struct packed {
        logic press;
        logic release_key;
    } held_ctl_t;

endpackage

`default_nettype wire

[rtl/keyboard_buffer_device_top.sv]
// Keyboard buffer device: key-down/key-up events and host commands (clear, get
// key, check key, set interrupt message) arrive on the req channel; every request
// produces exactly one response on the rsp channel, in order. A request is held
// in an input register, evaluated combinationally against the held-key set and
// typed-key FIFO, and its response lands in an output register. Throughput is
// one request per cycle while rsp_stall is low; the single evaluation step that
// reads and updates all state sets that rate. A stalled response only holds back
// the request behind it while the output register is occupied.
`default_nettype none

module keyboard_buffer_device_top #(
    parameter int FIFO_DEPTH      = kbd_pkg::FIFO_DEPTH_DEF,
    parameter int HELD_SLOT_COUNT = kbd_pkg::HELD_SLOT_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire kbd_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output kbd_pkg::rsp_t      rsp
);

    kbd_pkg::req_t      stage_reg;
    logic               stage_valid_reg;
    kbd_pkg::rsp_t      out_reg;
    kbd_pkg::rsp_t      out_next;
    logic               out_valid_reg;
    logic [15:0]        irq_msg_reg;
    logic [15:0]        irq_msg_next;
    logic               advance;
    logic               accept;
    kbd_pkg::op_t       op;
    kbd_pkg::fifo_ctl_t fifo_ctl;
    kbd_pkg::held_ctl_t held_ctl;
    logic [7:0]         fifo_head;
    logic               key_held;

    // Handshake
    assign advance   = stage_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = stage_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign op = kbd_pkg::op_t'(stage_reg.operation);

    // Command decode and response build
    always_comb
    begin
        fifo_ctl     = '0;
        held_ctl     = '0;
        out_next     = '0;
        irq_msg_next = irq_msg_reg;
        case (op)
            kbd_pkg::OP_KEY_DOWN:
            begin
                fifo_ctl.push = advance;
                held_ctl.press = advance;
                out_next.interrupt_request = (irq_msg_reg != 16'h0000);
                out_next.interrupt_message = irq_msg_reg;
            end
            kbd_pkg::OP_KEY_UP:
            begin
                held_ctl.release_key = advance;
                out_next.interrupt_request = (irq_msg_reg != 16'h0000);
                out_next.interrupt_message = irq_msg_reg;
            end
            kbd_pkg::OP_CLEAR:
            begin
                fifo_ctl.clear = advance;
            end
            kbd_pkg::OP_GET:
            begin
                fifo_ctl.pop = advance;
                out_next.read_valid = 1'b1;
                out_next.read_data  = fifo_head;
            end
            kbd_pkg::OP_CHECK:
            begin
                out_next.read_valid = 1'b1;
                out_next.read_data  = {7'b0000000, key_held};
            end
            kbd_pkg::OP_SET_IRQ:
            begin
                if (advance)
                begin
                    irq_msg_next = stage_reg.message_value;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    kbd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fifo_ctl),
        .key   (stage_reg.key_code[7:0]),
        .head  (fifo_head)
    );

    kbd_held #(
        .HELD_SLOT_COUNT (HELD_SLOT_COUNT)
    ) u_held (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (held_ctl),
        .key_code (stage_reg.key_code),
        .held     (key_held)
    );

    // Control and interrupt message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            irq_msg_reg     <= 16'h0000;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            irq_msg_reg <= irq_msg_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= req;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kbd_fifo.sv]
`default_nettype none

module kbd_fifo #(
    parameter int FIFO_DEPTH = kbd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kbd_pkg::fifo_ctl_t ctl,
    input  wire logic [7:0]        key,
    output logic [7:0]             head
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(FIFO_DEPTH);

    logic [7:0]       entries_reg  [FIFO_DEPTH];
    logic [7:0]       entries_next [FIFO_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Oldest entry, zero when empty
    assign head = (count_reg != '0) ? entries_reg[0] : 8'h00;

    // Next entries and fill count
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.pop && (count_reg != '0))
        begin
            for (int i = 0; i < FIFO_DEPTH - 1; i++)
            begin
                entries_next[i] = entries_reg[i + 1];
            end
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctl.push)
        begin
            if (count_reg != FULL)
            begin
                entries_next[count_reg[IDX_W-1:0]] = key;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                // full: drop the oldest
                for (int i = 0; i < FIFO_DEPTH - 1; i++)
                begin
                    entries_next[i] = entries_reg[i + 1];
                end
                entries_next[FIFO_DEPTH - 1] = key;
            end
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule

`default_nettype wire

[rtl/kbd_held.sv]
`default_nettype none

module kbd_held #(
    parameter int HELD_SLOT_COUNT = kbd_pkg::HELD_SLOT_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kbd_pkg::held_ctl_t ctl,
    input  wire logic [15:0]        key_code,
    output logic                    held
);

    localparam int N = HELD_SLOT_COUNT;

    logic [7:0]   slots_reg  [N];
    logic [7:0]   slots_next [N];
    logic [N-1:0] empty;
    logic [N-1:0] match;
    logic [N-1:0] first;

    // Per-slot empty and full-width match
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            empty[i] = (slots_reg[i] == 8'h00);
            match[i] = ({8'h00, slots_reg[i]} == key_code);
        end
    end

    // Lowest empty slot, one-hot
    assign first = empty & (~empty + N'(1));
    assign held  = |match;

    // Press fills first empty slot (slot 0 when none), release clears matches
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            slots_next[i] = slots_reg[i];
            if (ctl.press && (first[i] || ((i == 0) && (empty == '0))))
            begin
                slots_next[i] = key_code[7:0];
            end
            else if (ctl.release_key && match[i])
            begin
                slots_next[i] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '{default: '0};
        end
        else
        begin
            slots_reg <= slots_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kbd_checker.sv]
`default_nettype none
`include "keyboard_buffer_device_top_assert.svh"

module kbd_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire kbd_pkg::rsp_t rsp
);

    // Stalled response holds
    `KBD_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))

    // No response during reset
    `KBD_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !rsp_valid)

    // Once an accepted request has moved through the input register, a response is valid
    `KBD_ASSERT(a_req_rsp, (req_valid && !req_stall) |-> ##2 rsp_valid)

    // Empty output register never backs up the request side
    `KBD_ASSERT(a_no_stall_empty, !rsp_valid |-> !req_stall)

    // Unused response fields stay zero
    `KBD_ASSERT(a_zero_fields, rsp_valid |-> ((rsp.read_valid || (rsp.read_data == 8'h00)) &&
        (rsp.interrupt_request || (rsp.interrupt_message == 16'h0000))))

endmodule

bind keyboard_buffer_device_top kbd_checker u_kbd_checker (.*);

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TYPED_DEPTH = kbd_pkg::FIFO_DEPTH_DEF;
    localparam int HELD_SLOTS  = kbd_pkg::HELD_SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1425;
    localparam int WATCHDOG_LIMIT = 2000;

    // Command codes the block accepts but does nothing with
    localparam logic [2:0] OP_IGNORED_6 = 3'd6;
    localparam logic [2:0] OP_IGNORED_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid = 1'b0;
    logic req_stall;
    kbd_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    kbd_pkg::rsp_t rsp;

    keyboard_buffer_device_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Predicted device state
    logic [7:0]  typed_keys [TYPED_DEPTH];
    int          typed_count;
    logic [7:0]  held_keys [HELD_SLOTS];
    logic [15:0] irq_msg;

    kbd_pkg::rsp_t replies_due [$];
    int   mismatch_count = 0;
    bit   req_idle_on = 1'b1;
    bit   rsp_idle_on = 1'b1;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;
    kbd_pkg::rsp_t want;

    // Drop the oldest typed key, moving the rest down one place
    function automatic void shift_typed();
        int i;
        for (i = 0; i + 1 < TYPED_DEPTH; i++)
            typed_keys[i] = typed_keys[i + 1];
    endfunction

    // Apply one command to the predicted state and return its reply
    function automatic kbd_pkg::rsp_t compute_reply(kbd_pkg::req_t r);
        kbd_pkg::rsp_t o;
        logic [7:0] k;
        bit placed;
        int i;
        o = '0;
        k = r.key_code[7:0];
        placed = 1'b0;
        case (r.operation)
            kbd_pkg::OP_KEY_DOWN:
            begin
                for (i = 0; i < HELD_SLOTS; i++)
                begin
                    if (!placed && held_keys[i] == 8'h00)
                    begin
                        held_keys[i] = k;
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    held_keys[0] = k;
                if (typed_count < TYPED_DEPTH)
                begin
                    typed_keys[typed_count] = k;
                    typed_count++;
                end
                else
                begin
                    shift_typed();
                    typed_keys[TYPED_DEPTH - 1] = k;
                end
                o.interrupt_request = (irq_msg != 16'h0000);
                o.interrupt_message = irq_msg;
            end
            kbd_pkg::OP_KEY_UP:
            begin
                // full 16-bit compare: wide keys never match
                for (i = 0; i < HELD_SLOTS; i++)
                    if ({8'h00, held_keys[i]} == r.key_code)
                        held_keys[i] = 8'h00;
                o.interrupt_request = (irq_msg != 16'h0000);
                o.interrupt_message = irq_msg;
            end
            kbd_pkg::OP_CLEAR:
                typed_count = 0;
            kbd_pkg::OP_GET:
            begin
                o.read_valid = 1'b1;
                if (typed_count != 0)
                begin
                    o.read_data = typed_keys[0];
                    shift_typed();
                    typed_count--;
                end
            end
            kbd_pkg::OP_CHECK:
            begin
                o.read_valid = 1'b1;
                for (i = 0; i < HELD_SLOTS; i++)
                    if ({8'h00, held_keys[i]} == r.key_code)
                        o.read_data = 8'd1;
            end
            kbd_pkg::OP_SET_IRQ:
                irq_msg = r.message_value;
            default:
                ;
        endcase
        return o;
    endfunction

    // Present one command and wait for its transfer
    task automatic send_req(input kbd_pkg::req_t r);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        replies_due.push_back(compute_reply(r));
    endtask

    task automatic send_op(input logic [2:0] op, input logic [15:0] key,
                           input logic [15:0] msg);
        kbd_pkg::req_t r;
        r.operation = op;
        r.key_code = key;
        r.message_value = msg;
        send_req(r);
    endtask

    // Hold off new commands until every reply is back
    task automatic drain_replies();
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Random command, mostly keys from a small pool so releases and checks hit
    function automatic kbd_pkg::req_t random_req();
        kbd_pkg::req_t r;
        int pick;
        logic [7:0] low;
        pick = $urandom_range(0, 99);
        low = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 12));
        r.key_code = {($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00, low};
        r.message_value = 16'($urandom);
        if (pick < 35)
            r.operation = kbd_pkg::OP_KEY_DOWN;
        else if (pick < 55)
            r.operation = kbd_pkg::OP_KEY_UP;
        else if (pick < 70)
            r.operation = kbd_pkg::OP_CHECK;
        else if (pick < 85)
            r.operation = kbd_pkg::OP_GET;
        else if (pick < 89)
            r.operation = kbd_pkg::OP_CLEAR;
        else if (pick < 93)
        begin
            r.operation = kbd_pkg::OP_SET_IRQ;
            if ($urandom_range(0, 3) == 0)
                r.message_value = 16'h0000;
        end
        else if (pick < 96)
            r.operation = $urandom_range(0, 1) ? OP_IGNORED_6 : OP_IGNORED_7;
        else
        begin
            // fully random key on a key event or query
            case ($urandom_range(0, 2))
                0: r.operation = kbd_pkg::OP_KEY_DOWN;
                1: r.operation = kbd_pkg::OP_KEY_UP;
                default: r.operation = kbd_pkg::OP_CHECK;
            endcase
            r.key_code = 16'($urandom);
        end
        return r;
    endfunction

    // Reads right after reset: empty FIFO, all slots empty
    task automatic test_empty_reads();
        send_op(kbd_pkg::OP_GET, 16'h0000, 16'($urandom));
        send_op(kbd_pkg::OP_CHECK, 16'h0000, 16'($urandom));
        send_op(kbd_pkg::OP_CHECK, 16'hFFFF, 16'($urandom));
    endtask

    // Fill every slot, overflow both the held set and the typed FIFO
    task automatic test_held_set_overflow();
        int i;
        for (i = 1; i <= HELD_SLOTS; i++)
            send_op(kbd_pkg::OP_KEY_DOWN, 16'hFF00 | 16'(i), 16'($urandom));
        send_op(kbd_pkg::OP_KEY_DOWN, 16'h00FF, 16'hFFFF);
        send_op(kbd_pkg::OP_CHECK, 16'h00FF, 16'h0000);
        send_op(kbd_pkg::OP_CHECK, 16'hFF01, 16'h0000);
        send_op(kbd_pkg::OP_CHECK, 16'h0000, 16'h0000);
    endtask

    // Release a held key, then press a key whose low byte is zero
    task automatic test_release_and_zero_key();
        send_op(kbd_pkg::OP_KEY_UP, 16'h0002, 16'($urandom));
        send_op(kbd_pkg::OP_KEY_DOWN, 16'h0100, 16'($urandom));
    endtask

    // Pop the oldest key, clear, pop from an empty FIFO
    task automatic test_typed_fifo_clear();
        send_op(kbd_pkg::OP_GET, 16'($urandom), 16'($urandom));
        send_op(kbd_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        send_op(kbd_pkg::OP_GET, 16'($urandom), 16'($urandom));
    endtask

    // Interrupt message on key events, then the ignored codes
    task automatic test_irq_and_ignored();
        send_op(kbd_pkg::OP_SET_IRQ, 16'h0000, 16'hFFFF);
        send_op(kbd_pkg::OP_KEY_UP, 16'hFFFF, 16'h0000);
        send_op(kbd_pkg::OP_SET_IRQ, 16'hFFFF, 16'h0000);
        send_op(OP_IGNORED_6, 16'hFFFF, 16'hFFFF);
        send_op(OP_IGNORED_7, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // change idling in stretches, some with none at all
            if (n % 150 == 0)
            begin
                req_idle_on = ($urandom_range(0, 2) != 0);
                rsp_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n % 400 == 399)
                drain_replies();
            send_req(random_req());
        end
    endtask

    function automatic void check_field(input string label, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, label, exp_val, act_val);
        end
    endfunction

    // Response side: check each transfer, then draw the next stall
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: response with nothing pending, expected none, actual %h",
                         $time, rsp);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("read_valid", 16'(want.read_valid), 16'(rsp.read_valid));
                check_field("read_data", 16'(want.read_data), 16'(rsp.read_data));
                check_field("interrupt_request", 16'(want.interrupt_request),
                            16'(rsp.interrupt_request));
                check_field("interrupt_message", want.interrupt_message,
                            rsp.interrupt_message);
            end
            hold_cycles = rsp_idle_on ? $urandom_range(0, 6) : 0;
        end
        rsp_stall <= (hold_cycles > 0);
        if (hold_cycles > 0)
            hold_cycles--;
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        // falling edge at time zero so the asynchronous reset takes effect
        rst_n <= 1'b0;
        typed_keys = '{default: 8'h00};
        held_keys = '{default: 8'h00};
        typed_count = 0;
        irq_msg = 16'h0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_held_set_overflow();
        test_release_and_zero_key();
        test_typed_fifo_clear();
        test_irq_and_ignored();
        drain_replies();
        test_random_traffic();

        drain_replies();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/kbd_pkg.sv
rtl/kbd_fifo.sv
rtl/kbd_held.sv
rtl/keyboard_buffer_device_top.sv
rtl/kbd_checker.sv
tb/testbench.sv
